### sv/scancode_to_ascii_key_fifo_top_defines.svh
// Assertion macros for the scan code key ring
`ifndef SCANCODE_TO_ASCII_KEY_FIFO_TOP_DEFINES_SVH
`define SCANCODE_TO_ASCII_KEY_FIFO_TOP_DEFINES_SVH

`ifndef SYNTH
`define SKF_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("skf assertion failed");
`define SKF_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("skf implication failed");
`else
`define SKF_ASSERT(lbl, clk, rst_n, prop)
`define SKF_ASSERT_IMPL(lbl, clk, rst_n, ante, cons)
`endif

`endif

### sv/skf_pkg.sv
// Types, constants and key tables for the scan code key ring
`timescale 1ns / 1ps

package skf_pkg;

    localparam int unsigned DEF_RING_DEPTH = 256;
    localparam int unsigned TABLE_LEN      = 58;

    localparam logic CMD_SCAN = 1'b0;
    localparam logic CMD_READ = 1'b1;

    localparam logic [7:0] SC_LSHIFT_MAKE  = 8'h2A;
    localparam logic [7:0] SC_RSHIFT_MAKE  = 8'h36;
    localparam logic [7:0] SC_LSHIFT_BREAK = 8'hAA;
    localparam logic [7:0] SC_RSHIFT_BREAK = 8'hB6;
    localparam logic [7:0] SC_CAPS_MAKE    = 8'h3A;

    localparam logic [6:0] CASE_OFFSET = 7'd32;

    typedef struct packed {
        logic       command;
        logic [7:0] scan_byte;
    } t_in_beat;

    typedef struct packed {
        logic [6:0] ascii_code;
        logic       char_valid;
        logic       dropped;
        logic       has_input;
    } t_out_beat;

    localparam logic [6:0] PLAIN_MAP [TABLE_LEN] = '{
        7'h00, 7'h1B, 7'h31, 7'h32, 7'h33, 7'h34, 7'h35, 7'h36, 7'h37, 7'h38,
        7'h39, 7'h30, 7'h2D, 7'h3D, 7'h08, 7'h09, 7'h71, 7'h77, 7'h65, 7'h72,
        7'h74, 7'h79, 7'h75, 7'h69, 7'h6F, 7'h70, 7'h5B, 7'h5D, 7'h0A, 7'h00,
        7'h61, 7'h73, 7'h64, 7'h66, 7'h67, 7'h68, 7'h6A, 7'h6B, 7'h6C, 7'h3B,
        7'h27, 7'h60, 7'h00, 7'h5C, 7'h7A, 7'h78, 7'h63, 7'h76, 7'h62, 7'h6E,
        7'h6D, 7'h2C, 7'h2E, 7'h2F, 7'h00, 7'h2A, 7'h00, 7'h20
    };

    localparam logic [6:0] SHIFT_MAP [TABLE_LEN] = '{
        7'h00, 7'h1B, 7'h21, 7'h40, 7'h23, 7'h24, 7'h25, 7'h5E, 7'h26, 7'h2A,
        7'h28, 7'h29, 7'h5F, 7'h2B, 7'h08, 7'h09, 7'h51, 7'h57, 7'h45, 7'h52,
        7'h54, 7'h59, 7'h55, 7'h49, 7'h4F, 7'h50, 7'h7B, 7'h7D, 7'h0A, 7'h00,
        7'h41, 7'h53, 7'h44, 7'h46, 7'h47, 7'h48, 7'h4A, 7'h4B, 7'h4C, 7'h3A,
        7'h22, 7'h7E, 7'h00, 7'h7C, 7'h5A, 7'h58, 7'h43, 7'h56, 7'h42, 7'h4E,
        7'h4D, 7'h3C, 7'h3E, 7'h3F, 7'h00, 7'h2A, 7'h00, 7'h20
    };

    function automatic logic [6:0] translate(input logic [7:0] code,
                                             input logic       shift,
                                             input logic       caps);
        logic [6:0] c;
        c = 7'd0;
        if (code < 8'(TABLE_LEN)) begin
            c = shift ? SHIFT_MAP[code[5:0]] : PLAIN_MAP[code[5:0]];
            if (caps) begin
                if (c >= 7'h61 && c <= 7'h7A) begin
                    c = c - CASE_OFFSET;
                end else if (c >= 7'h41 && c <= 7'h5A && shift) begin
                    c = c + CASE_OFFSET;
                end
            end
        end
        return c;
    endfunction

endpackage

### sv/scancode_to_ascii_key_fifo_top.sv
// Top level: scan code set 1 translator feeding a character ring
`timescale 1ns / 1ps
`include "scancode_to_ascii_key_fifo_top_defines.svh"

// Takes one beat per cycle: either a set 1 scan code or a read request. Shift and
// caps lock state, translation and the ring pointers are all resolved in the cycle
// the beat is accepted; its result appears in the output register on the next
// cycle, one result per beat. Input is taken whenever the output register is empty
// or is being drained in the same cycle, so the sustained rate is one beat per
// clock while i_out_ready stays high; the single-port ring does one write or one
// registered read per beat. The ring holds RING_DEPTH-1 characters; a character
// arriving when full is reported with dropped set and discarded. No clearing pass after reset.
module scancode_to_ascii_key_fifo_top
    import skf_pkg::*;
#(
    parameter int unsigned RING_DEPTH = DEF_RING_DEPTH
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_ready,
    input  t_in_beat  i_in_data,
    output logic      o_out_valid,
    input  logic      i_out_ready,
    output t_out_beat o_out_data
);

    localparam int unsigned PTR_W = $clog2(RING_DEPTH);
    localparam logic [PTR_W-1:0] LAST_IDX = PTR_W'(RING_DEPTH - 1);

    logic [6:0]       r_ring [RING_DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic             r_shift, n_shift;
    logic             r_caps, n_caps;
    logic             r_out_valid;
    t_out_beat        r_out, n_out;
    logic             r_from_ring, n_from_ring;
    logic [6:0]       r_rd_data;

    logic             accept;
    logic             do_push;
    logic             do_pop;
    logic [6:0]       ch;
    logic [PTR_W-1:0] wr_adv;
    logic [PTR_W-1:0] rd_adv;

    assign o_in_ready = !r_out_valid || i_out_ready;
    assign accept     = i_in_valid && o_in_ready;

    assign wr_adv = (r_wr_ptr == LAST_IDX) ? '0 : r_wr_ptr + 1'b1;
    assign rd_adv = (r_rd_ptr == LAST_IDX) ? '0 : r_rd_ptr + 1'b1;

    always_comb begin
        n_shift     = r_shift;
        n_caps      = r_caps;
        n_wr_ptr    = r_wr_ptr;
        n_rd_ptr    = r_rd_ptr;
        do_push     = 1'b0;
        do_pop      = 1'b0;
        ch          = 7'd0;
        n_from_ring = 1'b0;
        n_out       = '0;
        if (i_in_data.command == CMD_READ) begin
            if (r_rd_ptr != r_wr_ptr) begin
                do_pop      = 1'b1;
                n_rd_ptr    = rd_adv;
                n_from_ring = 1'b1;
                n_out.char_valid = 1'b1;
            end
        end else if (i_in_data.scan_byte == SC_LSHIFT_MAKE ||
                     i_in_data.scan_byte == SC_RSHIFT_MAKE) begin
            n_shift = 1'b1;
        end else if (i_in_data.scan_byte == SC_LSHIFT_BREAK ||
                     i_in_data.scan_byte == SC_RSHIFT_BREAK) begin
            n_shift = 1'b0;
        end else if (i_in_data.scan_byte == SC_CAPS_MAKE) begin
            n_caps = !r_caps;
        end else if (!i_in_data.scan_byte[7]) begin
            ch = translate(i_in_data.scan_byte, r_shift, r_caps);
            n_out.ascii_code = ch;
            if (ch != 7'd0) begin
                if (wr_adv != r_rd_ptr) begin
                    do_push          = 1'b1;
                    n_wr_ptr         = wr_adv;
                    n_out.char_valid = 1'b1;
                end else begin
                    n_out.dropped = 1'b1;
                end
            end
        end
        n_out.has_input = (n_rd_ptr != n_wr_ptr);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr    <= '0;
            r_rd_ptr    <= '0;
            r_shift     <= 1'b0;
            r_caps      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (accept) begin
                r_wr_ptr <= n_wr_ptr;
                r_rd_ptr <= n_rd_ptr;
                r_shift  <= n_shift;
                r_caps   <= n_caps;
            end
            if (o_in_ready) begin
                r_out_valid <= i_in_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_out       <= n_out;
            r_from_ring <= n_from_ring;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept && do_push) begin
            r_ring[r_wr_ptr] <= ch;
        end
        if (accept && do_pop) begin
            r_rd_data <= r_ring[r_rd_ptr];
        end
    end

    assign o_out_valid = r_out_valid;

    always_comb begin
        o_out_data = r_out;
        if (r_from_ring) begin
            o_out_data.ascii_code = r_rd_data;
        end
    end

    `SKF_ASSERT(a_no_valid_and_drop, i_clk, i_rst_n, !(o_out_valid && o_out_data.char_valid && o_out_data.dropped))
    `SKF_ASSERT_IMPL(a_drop_has_char, i_clk, i_rst_n, o_out_valid && o_out_data.dropped, o_out_data.ascii_code != 7'd0 && o_out_data.has_input)
    `SKF_ASSERT_IMPL(a_result_held, i_clk, i_rst_n, o_out_valid && !i_out_ready, ##1 o_out_valid && $stable(o_out_data))
    `SKF_ASSERT(a_ptrs_in_range, i_clk, i_rst_n, r_wr_ptr <= LAST_IDX && r_rd_ptr <= LAST_IDX)

endmodule
